[sv/msp_pkg.sv]
package msp_pkg;

  localparam int DEF_CHANNELS = 16;
  localparam int DEF_NOTES    = 128;
  localparam int GROUP_BITS   = 32;

  typedef enum logic [1:0] {
    MODE_ON      = 2'd0,
    MODE_OFF     = 2'd1,
    MODE_PRESS   = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_ON   = 2'd0,
    KIND_OFF  = 2'd1,
    KIND_MASK = 2'd2
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_MOD  = 1'b1
  } state_t;

  typedef struct packed {
    logic [GROUP_BITS-1:0] held;
    logic [GROUP_BITS-1:0] captured;
    logic [GROUP_BITS-1:0] sounding;
  } map_entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

[sv/msp_mem.sv]
module msp_mem import msp_pkg::*; #(
  parameter int DEPTH = DEF_CHANNELS * ((DEF_NOTES + GROUP_BITS - 1) / GROUP_BITS),
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] wr_addr,
  input  map_entry_t    wr_data,
  output map_entry_t    rd_data
);

  map_entry_t       ram [DEPTH];
  logic [DEPTH-1:0] valid_r;
  map_entry_t       rdata_r;
  logic             rvalid_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      ram[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rdata_r <= ram[rd_addr];
    end
  end

  // entries not yet written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rvalid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rvalid_r ? rdata_r : '0;

endmodule

[sv/msp_ctrl.sv]
module msp_ctrl import msp_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS,
  parameter int NOTES    = DEF_NOTES,
  parameter int GROUPS   = (NOTES + GROUP_BITS - 1) / GROUP_BITS,
  parameter int DEPTH    = CHANNELS * GROUPS,
  parameter int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_mode,
  input  logic [3:0]            in_chan,
  input  logic [6:0]            in_key,
  input  logic [6:0]            in_vel,
  output mem_ctl_t              mem_ctl,
  output logic [AW-1:0]         rd_addr,
  output logic [AW-1:0]         wr_addr,
  output map_entry_t            wr_data,
  input  map_entry_t            rd_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output kind_t                 out_kind,
  output logic [3:0]            out_chan,
  output logic [6:0]            out_key,
  output logic [6:0]            out_vel,
  output logic [1:0]            out_grp,
  output logic [GROUP_BITS-1:0] out_mask,
  output logic                  out_last
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam logic [GW-1:0] LAST_G = GW'(GROUPS - 1);

  function automatic logic [AW-1:0] addr_of(logic [CW-1:0] c, logic [GW-1:0] g);
    return AW'(32'(c) * GROUPS + 32'(g));
  endfunction

  function automatic logic [GROUP_BITS-1:0] group_valid(logic [GW-1:0] g);
    int left;
    left = NOTES - 32'(g) * GROUP_BITS;
    if (left >= GROUP_BITS) begin
      return '1;
    end
    return (GROUP_BITS'(1) << left) - GROUP_BITS'(1);
  endfunction

  state_t              state_r, state_nxt;
  mode_t               mode_r;
  logic [3:0]          ch_r;
  logic [6:0]          key_r;
  logic [6:0]          vel_r;
  logic                touch_r;
  logic [GW-1:0]       grp_r, grp_nxt;
  logic [CHANNELS-1:0] pedal_r;

  logic                  out_valid_r, out_valid_nxt;
  kind_t                 out_kind_r;
  logic [3:0]            out_chan_r;
  logic [6:0]            out_key_r;
  logic [6:0]            out_vel_r;
  logic [1:0]            out_grp_r;
  logic [GROUP_BITS-1:0] out_mask_r;
  logic                  out_last_r;

  mode_t           in_mode_c;
  logic            in_pedal_ev, in_ch_ok, in_key_ok, in_touch;
  logic [GW-1:0]   in_grp;
  logic [CW-1:0]   in_ch_idx, ch_idx_r;
  logic            capture, go, multi, load;
  logic            need_out, pedal_on;
  kind_t           kind_c;
  logic [GROUP_BITS-1:0] bit_c, mask_c;
  map_entry_t      mod_c;

  assign in_mode_c   = mode_t'(in_mode);
  assign in_pedal_ev = (in_mode_c == MODE_PRESS) || (in_mode_c == MODE_RELEASE);
  assign in_ch_ok    = 32'(in_chan) < CHANNELS;
  assign in_key_ok   = 32'(in_key) < NOTES;
  assign in_touch    = in_ch_ok && (in_pedal_ev || in_key_ok);
  assign in_grp      = in_pedal_ev ? '0 : GW'(in_key[6:5]);
  assign in_ch_idx   = in_chan[CW-1:0];
  assign ch_idx_r    = ch_r[CW-1:0];
  assign pedal_on    = pedal_r[ch_idx_r];
  assign bit_c       = GROUP_BITS'(1) << key_r[4:0];
  assign multi       = touch_r && ((mode_r == MODE_PRESS) || (mode_r == MODE_RELEASE));

  // modify the entry read for the held item
  always_comb begin
    mod_c    = rd_data;
    need_out = 1'b0;
    kind_c   = KIND_ON;
    mask_c   = '0;
    case (mode_r)
      MODE_ON: begin
        need_out = 1'b1;
        kind_c   = KIND_ON;
        mod_c.sounding = rd_data.sounding | bit_c;
        if (pedal_on) begin
          mod_c.held = rd_data.held & ~bit_c;
        end
      end
      MODE_OFF: begin
        kind_c = KIND_OFF;
        mod_c.sounding = rd_data.sounding & ~bit_c;
        if (touch_r && pedal_on && ((rd_data.captured & bit_c) != '0)) begin
          mod_c.held = rd_data.held | bit_c;
        end else begin
          need_out = 1'b1;
        end
      end
      MODE_PRESS: begin
        mod_c.captured = rd_data.sounding;
      end
      MODE_RELEASE: begin
        need_out       = touch_r;
        kind_c         = KIND_MASK;
        mask_c         = rd_data.held & group_valid(grp_r);
        mod_c.captured = '0;
        mod_c.held     = '0;
      end
      default: begin
        need_out = 1'b0;
      end
    endcase
  end

  assign go = !need_out || !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    grp_nxt   = grp_r;
    capture   = 1'b0;
    load      = 1'b0;
    in_ready  = 1'b0;
    mem_ctl   = '0;
    rd_addr   = addr_of(in_ch_idx, in_grp);
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          capture       = 1'b1;
          grp_nxt       = in_grp;
          mem_ctl.rd_en = in_touch;
          state_nxt     = ST_MOD;
        end
      end
      ST_MOD: begin
        if (go) begin
          mem_ctl.wr_en = touch_r;
          load          = need_out;
          if (multi && (grp_r != LAST_G)) begin
            grp_nxt       = grp_r + GW'(1);
            mem_ctl.rd_en = 1'b1;
            rd_addr       = addr_of(ch_idx_r, grp_r + GW'(1));
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign wr_addr = addr_of(ch_idx_r, grp_r);
  assign wr_data = mod_c;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pedal_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (go && (state_r == ST_MOD) && touch_r) begin
        if (mode_r == MODE_PRESS) begin
          pedal_r[ch_idx_r] <= 1'b1;
        end else if (mode_r == MODE_RELEASE) begin
          pedal_r[ch_idx_r] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
    if (capture) begin
      mode_r  <= in_mode_c;
      ch_r    <= in_chan;
      key_r   <= in_key;
      vel_r   <= in_vel;
      touch_r <= in_touch;
    end
    if (load) begin
      out_kind_r <= kind_c;
      out_chan_r <= ch_r;
      if (kind_c == KIND_MASK) begin
        out_key_r  <= '0;
        out_vel_r  <= '0;
        out_grp_r  <= 2'(grp_r);
        out_mask_r <= mask_c;
        out_last_r <= (grp_r == LAST_G);
      end else begin
        out_key_r  <= key_r;
        out_vel_r  <= vel_r;
        out_grp_r  <= '0;
        out_mask_r <= '0;
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_chan  = out_chan_r;
  assign out_key   = out_key_r;
  assign out_vel   = out_vel_r;
  assign out_grp   = out_grp_r;
  assign out_mask  = out_mask_r;
  assign out_last  = out_last_r;

endmodule

[sv/midi_sostenuto_pedal_unit.sv]
// Events are taken one at a time in the idle state, which reads the map entry;
// the modify state writes it back, registering any result, and holds while a
// result is due and the last is untaken. Pedal events repeat this per group.
// Reset (rst_n low, synchronous) clears pedal state and the per-entry valid
// bits of the map memory at once; no clearing pass follows.
module midi_sostenuto_pedal_unit import msp_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS,
  parameter int NOTES    = DEF_NOTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // chan[3:0], key_number[10:4], vel[17:11], zero
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // out_chan[3:0], out_key[10:4], out_vel[17:11],
                                  // group_index[19:18], off_mask[51:20], zero
  output logic [1:0]  out_tuser,  // kind[1:0]
  output logic        out_tlast
);

  localparam int GROUPS = (NOTES + GROUP_BITS - 1) / GROUP_BITS;
  localparam int DEPTH  = CHANNELS * GROUPS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mem_ctl_t              mem_ctl;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  map_entry_t            wr_data;
  map_entry_t            rd_data;
  kind_t                 out_kind;
  logic [3:0]            out_chan;
  logic [6:0]            out_key;
  logic [6:0]            out_vel;
  logic [1:0]            out_grp;
  logic [GROUP_BITS-1:0] out_mask;

  msp_ctrl #(
    .CHANNELS (CHANNELS),
    .NOTES    (NOTES),
    .GROUPS   (GROUPS),
    .DEPTH    (DEPTH),
    .AW       (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser),
    .in_chan   (in_tdata[3:0]),
    .in_key    (in_tdata[10:4]),
    .in_vel    (in_tdata[17:11]),
    .mem_ctl   (mem_ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_data   (rd_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_kind),
    .out_chan  (out_chan),
    .out_key   (out_key),
    .out_vel   (out_vel),
    .out_grp   (out_grp),
    .out_mask  (out_mask),
    .out_last  (out_tlast)
  );

  msp_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  assign out_tuser = out_kind;
  assign out_tdata = {4'b0, out_mask, out_grp, out_vel, out_key, out_chan};

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in work");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.rd_en && mem_ctl.wr_en |-> rd_addr != wr_addr)
    else $error("map read and write hit one entry in the same cycle");

  a_note_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != 2'(KIND_MASK)) |-> out_tlast)
    else $error("note result not marked last");

endmodule
